[hw/rtl/rdc_pkg.sv]
// Package for the grid DDA wall raycaster.
// Holds fixed-point widths, map geometry, register codes, the sequencer state type
// and the divider request type. Depends on nothing.
`default_nettype none
package rdc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAP_BITS   = 5;
    localparam int MAP_AW     = 2 * MAP_BITS;
    localparam int TEX_BITS   = 6;
    localparam int MAX_STEPS  = 64;
    localparam int STEP_W     = 7;
    localparam int DIV_NUM_W  = 33;
    localparam int DIV_DEN_W  = 40;
    localparam int DIV_CNT_W  = 6;
    localparam int DIST_W     = 40;
    localparam int RAY_W      = 33;
    localparam int CAMX_W     = 30;
    localparam int PROD_W     = 48;
    localparam int CELL_W     = 4;
    localparam logic [23:0] LINE_MAX  = 24'hFFFFFF;
    localparam logic [27:0] START_MAX = 28'hFFFFFFF;

    typedef enum logic [2:0] {
        REG_POS_X   = 3'd0,
        REG_POS_Y   = 3'd1,
        REG_DIR_X   = 3'd2,
        REG_DIR_Y   = 3'd3,
        REG_PLANE_X = 3'd4,
        REG_PLANE_Y = 3'd5,
        REG_SCR_W   = 3'd6,
        REG_SCR_H   = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAMX,
        ST_PROD,
        ST_RAY,
        ST_DX,
        ST_SX,
        ST_DY,
        ST_SY,
        ST_WALK,
        ST_CHECK,
        ST_LINE,
        ST_SPAN,
        ST_TSTEP,
        ST_TSTART,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

endpackage
`default_nettype wire

[hw/rtl/rdc_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Uses rdc_pkg for widths and the request struct.
`default_nettype none
module rdc_div
    import rdc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire div_req_t             req,
    output logic                      done,
    output logic [DIV_NUM_W-1:0]      quo
);

    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] q_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 fits;

    assign rem_sh = {rem_reg, q_reg[DIV_NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !run_reg)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !run_reg)
        begin
            rem_reg <= '0;
            den_reg <= req.den;
            q_reg   <= req.num;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DEN_W-1:0];
            q_reg   <= {q_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule
`default_nettype wire

[hw/rtl/rdc_map.sv]
// Map cell memory: one write port, one read port with registered read data.
// Uses rdc_pkg for the address and cell widths.
`default_nettype none
module rdc_map
    import rdc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [MAP_AW-1:0] waddr,
    input  wire logic [CELL_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [MAP_AW-1:0] raddr,
    output logic      [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [2**MAP_AW];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[hw/rtl/grid_dda_wall_raycaster_top.sv]
// Grid DDA wall raycaster, top level; uses rdc_pkg, rdc_div and rdc_map.
// A cast walks at most 64 cells, each costing a map read; up to seven divisions on one
//   shared divider set most of a cast's duration.
// A cell write does not raise busy. One request is in flight at a time; busy covers all of a cast.
// After reset the map is cleared, one cell a cycle, all 1024 cells, while busy is high.
`default_nettype none
module grid_dda_wall_raycaster_top
    import rdc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB-style configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Request side
    input  wire logic        start,
    output logic             busy,
    input  wire logic        kind,
    input  wire logic [4:0]  cell_x,
    input  wire logic [4:0]  cell_y,
    input  wire logic [3:0]  cell_code,
    input  wire logic [10:0] column,
    // Result side, one cycle strobe
    output logic             done,
    output logic [10:0]      out_column,
    output logic             hit,
    output logic [3:0]       wall_code,
    output logic             side,
    output logic [23:0]      wall_dist,
    output logic [10:0]      draw_start,
    output logic [10:0]      draw_end,
    output logic [5:0]       tex_x,
    output logic [23:0]      tex_step,
    output logic [27:0]      tex_start
);

    // Configuration registers.
    logic        [20:0] pos_x_reg, pos_y_reg;
    logic signed [17:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic        [11:0] scr_w_reg, scr_h_reg;
    logic               cfg_wr;
    cfg_reg_t           cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= 21'd65536;
            pos_y_reg   <= 21'd65536;
            dir_x_reg   <= -18'sd65536;
            dir_y_reg   <= '0;
            plane_x_reg <= '0;
            plane_y_reg <= 18'sd43254;
            scr_w_reg   <= 12'd640;
            scr_h_reg   <= 12'd480;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_POS_X:   pos_x_reg   <= pwdata[20:0];
                REG_POS_Y:   pos_y_reg   <= pwdata[20:0];
                REG_DIR_X:   dir_x_reg   <= pwdata[17:0];
                REG_DIR_Y:   dir_y_reg   <= pwdata[17:0];
                REG_PLANE_X: plane_x_reg <= pwdata[17:0];
                REG_PLANE_Y: plane_y_reg <= pwdata[17:0];
                REG_SCR_W:   scr_w_reg   <= pwdata[11:0];
                REG_SCR_H:   scr_h_reg   <= pwdata[11:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_POS_X:   prdata = {11'b0, pos_x_reg};
            REG_POS_Y:   prdata = {11'b0, pos_y_reg};
            REG_DIR_X:   prdata = {14'b0, dir_x_reg};
            REG_DIR_Y:   prdata = {14'b0, dir_y_reg};
            REG_PLANE_X: prdata = {14'b0, plane_x_reg};
            REG_PLANE_Y: prdata = {14'b0, plane_y_reg};
            REG_SCR_W:   prdata = {20'b0, scr_w_reg};
            REG_SCR_H:   prdata = {20'b0, scr_h_reg};
            default:     prdata = '0;
        endcase
    end

    // A zero screen size counts as one.
    logic [11:0] w_eff, h_eff;
    logic [10:0] half_h;
    assign w_eff  = (scr_w_reg == '0) ? 12'd1 : scr_w_reg;
    assign h_eff  = (scr_h_reg == '0) ? 12'd1 : scr_h_reg;
    assign half_h = h_eff[11:1];

    // Sequencer.
    state_t state_reg, state_next;
    logic   [MAP_AW-1:0] clr_cnt_reg;
    logic   div_go_reg;
    logic   div_done;
    logic   [DIV_NUM_W-1:0] quo;
    div_req_t div_req;
    logic   in_div;
    logic   take;
    logic   [10:0] column_hold;

    // Map port signals: clearing sweep, cell writes and walk reads.
    logic              map_we, map_re;
    logic [MAP_AW-1:0] map_waddr;
    logic [CELL_W-1:0] map_wdata, map_rdata;

    // Cast datapath registers.
    logic        [10:0]        col_reg;
    logic signed [CAMX_W-1:0]  camx_reg;
    logic signed [PROD_W-1:0]  px_reg, py_reg;
    logic signed [RAY_W-1:0]   rx_reg, ry_reg;
    logic                      xinf_reg, yinf_reg;
    logic        [DIST_W-1:0]  sx_reg, sy_reg, perp_reg;
    logic        [RAY_W-1:0]   dx_reg, dy_reg;
    logic signed [STEP_W-1:0]  mx_reg, my_reg;
    logic        [STEP_W-1:0]  step_cnt_reg;
    logic                      side_reg, hit_reg;
    logic        [CELL_W-1:0]  code_reg;
    logic        [23:0]        lh_reg, step_reg;
    logic        [31:0]        wprod_reg;
    logic        [10:0]        ds_reg, de_reg;
    logic        [22:0]        texv_reg;
    logic        [TEX_BITS-1:0] tx_reg;
    logic        [27:0]        tstart_reg;

    // Ray arithmetic.
    logic signed [PROD_W-1:0] px_adj, py_adj;
    logic signed [RAY_W-1:0]  rx_calc, ry_calc;
    logic        [RAY_W-1:0]  ax, ay;
    logic        [16:0]       fx, fy;

    assign px_adj  = px_reg + (px_reg[PROD_W-1] ? 48'sd65535 : 48'sd0);
    assign py_adj  = py_reg + (py_reg[PROD_W-1] ? 48'sd65535 : 48'sd0);
    assign rx_calc = {{15{dir_x_reg[17]}}, dir_x_reg} + {px_adj[PROD_W-1], px_adj[47:16]};
    assign ry_calc = {{15{dir_y_reg[17]}}, dir_y_reg} + {py_adj[PROD_W-1], py_adj[47:16]};
    assign ax = rx_reg[RAY_W-1] ? RAY_W'(-rx_reg) : RAY_W'(rx_reg);
    assign ay = ry_reg[RAY_W-1] ? RAY_W'(-ry_reg) : RAY_W'(ry_reg);
    assign fx = rx_reg[RAY_W-1] ? {1'b0, pos_x_reg[15:0]} : 17'h10000 - {1'b0, pos_x_reg[15:0]};
    assign fy = ry_reg[RAY_W-1] ? {1'b0, pos_y_reg[15:0]} : 17'h10000 - {1'b0, pos_y_reg[15:0]};

    // One DDA step. Ties go to y; an infinite axis never steps.
    logic                     take_x;
    logic signed [STEP_W-1:0] mx_new, my_new;
    logic                     in_map;
    assign take_x = xinf_reg ? 1'b0 : (yinf_reg ? 1'b1 : (sx_reg < sy_reg));
    assign mx_new = take_x ? (rx_reg[RAY_W-1] ? mx_reg - 7'sd1 : mx_reg + 7'sd1) : mx_reg;
    assign my_new = take_x ? my_reg : (ry_reg[RAY_W-1] ? my_reg - 7'sd1 : my_reg + 7'sd1);
    assign in_map = (mx_new[6:5] == 2'b00) && (my_new[6:5] == 2'b00);

    // Span and texture column.
    logic [22:0] lh_half;
    logic [23:0] de_sum;
    logic [15:0] wall_frac;
    logic [TEX_BITS-1:0] tx_raw;
    logic        mirror;
    logic [46:0] tprod;
    logic [31:0] wmul;
    assign lh_half   = lh_reg[23:1];
    assign de_sum    = {13'b0, half_h} + {1'b0, lh_half};
    assign wall_frac = (side_reg ? pos_x_reg[15:0] : pos_y_reg[15:0]) + wprod_reg[31:16];
    assign tx_raw    = wall_frac[FRAC_BITS-1 -: TEX_BITS];
    assign mirror    = (!side_reg && !rx_reg[RAY_W-1] && rx_reg != '0) ||
                       (side_reg && ry_reg[RAY_W-1]);
    assign tprod     = texv_reg * step_reg;
    assign wmul      = perp_reg[31:0] * (side_reg ? rx_reg[31:0] : ry_reg[31:0]);

    assign take   = start && !busy;
    assign in_div = (state_reg == ST_CAMX) || (state_reg == ST_DX) || (state_reg == ST_SX) ||
                    (state_reg == ST_DY) || (state_reg == ST_SY) ||
                    (state_reg == ST_LINE) || (state_reg == ST_TSTEP);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_cnt_reg == '1) state_next = ST_IDLE;
            ST_IDLE:   if (take && kind) state_next = ST_CAMX;
            ST_CAMX:   if (div_done) state_next = ST_PROD;
            ST_PROD:   state_next = ST_RAY;
            ST_RAY:    state_next = (rx_calc == '0 && ry_calc == '0) ? ST_OUT : ST_DX;
            ST_DX:     if (div_done) state_next = ST_SX;
            ST_SX:     if (div_done) state_next = ST_DY;
            ST_DY:     if (div_done) state_next = ST_SY;
            ST_SY:     if (div_done) state_next = ST_WALK;
            ST_WALK:
            begin
                if (step_cnt_reg == STEP_W'(MAX_STEPS) || !in_map)
                    state_next = ST_OUT;
                else
                    state_next = ST_CHECK;
            end
            ST_CHECK:  state_next = (map_rdata != '0) ? ST_LINE : ST_WALK;
            ST_LINE:   if (div_done) state_next = ST_SPAN;
            ST_SPAN:   state_next = ST_TSTEP;
            ST_TSTEP:  if (div_done) state_next = ST_TSTART;
            ST_TSTART: state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Divider operands per state.
    always_comb
    begin
        div_req.start = in_div && !div_go_reg;
        div_req.num   = '0;
        div_req.den   = '0;
        unique case (state_reg)
            ST_CAMX:
            begin
                div_req.num = {5'b0, column_hold, 17'b0};
                div_req.den = {28'b0, w_eff};
            end
            ST_DX:
            begin
                div_req.num = {1'b1, 32'b0};
                div_req.den = {7'b0, ax};
            end
            ST_SX:
            begin
                div_req.num = {fx, 16'b0};
                div_req.den = {7'b0, ax};
            end
            ST_DY:
            begin
                div_req.num = {1'b1, 32'b0};
                div_req.den = {7'b0, ay};
            end
            ST_SY:
            begin
                div_req.num = {fy, 16'b0};
                div_req.den = {7'b0, ay};
            end
            ST_LINE:
            begin
                div_req.num = {5'b0, h_eff, 16'b0};
                div_req.den = perp_reg;
            end
            ST_TSTEP:
            begin
                div_req.num = DIV_NUM_W'(TEX_BITS'(0) + (1 << (TEX_BITS + FRAC_BITS)));
                div_req.den = {16'b0, lh_reg};
            end
            default: ;
        endcase
    end

    assign column_hold = col_reg;

    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = {cell_y, cell_x};
        map_wdata = cell_code;
        map_re    = (state_reg == ST_WALK);
        if (state_reg == ST_CLEAR)
        begin
            map_we    = 1'b1;
            map_waddr = clr_cnt_reg;
            map_wdata = '0;
        end
        else if (state_reg == ST_IDLE && take && !kind)
        begin
            map_we = 1'b1;
        end
    end

    rdc_map u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr ({my_new[MAP_BITS-1:0], mx_new[MAP_BITS-1:0]}),
        .rdata (map_rdata)
    );

    rdc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            div_go_reg  <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (div_req.start)
                div_go_reg <= 1'b1;
            else if (div_done)
                div_go_reg <= 1'b0;
            if (state_reg == ST_IDLE)
                hit_reg <= 1'b0;
            else if (state_reg == ST_TSTART)
                hit_reg <= 1'b1;
        end
    end

    // Datapath registers, loaded as the sequencer passes through each step.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (take) col_reg <= column;
            ST_CAMX:
                if (div_done) camx_reg <= $signed({1'b0, quo[28:0]}) - 30'sd65536;
            ST_PROD:
            begin
                px_reg <= plane_x_reg * camx_reg;
                py_reg <= plane_y_reg * camx_reg;
            end
            ST_RAY:
            begin
                rx_reg       <= rx_calc;
                ry_reg       <= ry_calc;
                xinf_reg     <= (rx_calc == '0);
                yinf_reg     <= (ry_calc == '0);
                mx_reg       <= {2'b0, pos_x_reg[20:16]};
                my_reg       <= {2'b0, pos_y_reg[20:16]};
                step_cnt_reg <= '0;
            end
            ST_DX:
                if (div_done) dx_reg <= quo;
            ST_SX:
                if (div_done) sx_reg <= {7'b0, quo};
            ST_DY:
                if (div_done) dy_reg <= quo;
            ST_SY:
                if (div_done) sy_reg <= {7'b0, quo};
            ST_WALK:
            begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
                mx_reg       <= mx_new;
                my_reg       <= my_new;
                side_reg     <= !take_x;
                if (take_x)
                begin
                    perp_reg <= sx_reg;
                    sx_reg   <= sx_reg + {7'b0, dx_reg};
                end
                else
                begin
                    perp_reg <= sy_reg;
                    sy_reg   <= sy_reg + {7'b0, dy_reg};
                end
            end
            ST_CHECK:
                code_reg <= map_rdata;
            ST_LINE:
            begin
                if (div_done)
                begin
                    if (perp_reg == '0 || quo[32:24] != '0)
                        lh_reg <= LINE_MAX;
                    else
                        lh_reg <= quo[23:0];
                    wprod_reg <= wmul;
                end
            end
            ST_SPAN:
            begin
                ds_reg   <= ({1'b0, lh_half} >= {13'b0, half_h}) ? 11'd0 : half_h - lh_half[10:0];
                if (de_sum >= {12'b0, h_eff})
                    de_reg <= (h_eff - 12'd1 > 12'd2047) ? 11'h7FF : 11'(h_eff - 12'd1);
                else
                    de_reg <= (de_sum > 24'd2047) ? 11'h7FF : de_sum[10:0];
                texv_reg <= ({1'b0, lh_half} > {13'b0, half_h}) ?
                            23'(lh_half - {12'b0, half_h}) : 23'd0;
                tx_reg   <= mirror ? ~tx_raw : tx_raw;
            end
            ST_TSTEP:
                if (div_done) step_reg <= (lh_reg == '0) ? LINE_MAX : quo[23:0];
            ST_TSTART:
                tstart_reg <= (lh_reg == '0) ? 28'd0 :
                              ((tprod[46:28] != '0) ? START_MAX : tprod[27:0]);
            default: ;
        endcase
    end

    // Results: all hit-related fields read zero on a miss.
    assign busy       = (state_reg != ST_IDLE);
    assign done       = (state_reg == ST_OUT);
    assign out_column = col_reg;
    assign hit        = hit_reg;
    assign wall_code  = hit_reg ? code_reg : '0;
    assign side       = hit_reg ? side_reg : 1'b0;
    assign wall_dist  = hit_reg ? ((perp_reg[39:24] != '0) ? LINE_MAX : perp_reg[23:0]) : '0;
    assign draw_start = hit_reg ? ds_reg : '0;
    assign draw_end   = hit_reg ? de_reg : '0;
    assign tex_x      = hit_reg ? tx_reg : '0;
    assign tex_step   = hit_reg ? step_reg : '0;
    assign tex_start  = hit_reg ? tstart_reg : '0;

endmodule
`default_nettype wire

[hw/rtl/rdc_chk.sv]
// Port-level checker for the raycaster and its bind to the top level.
// Sees only the top-level ports; depends on nothing else.
`default_nettype none
module rdc_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        kind,
    input wire logic        done,
    input wire logic        hit,
    input wire logic [3:0]  wall_code,
    input wire logic [23:0] wall_dist,
    input wire logic [23:0] tex_step
);

    // A result only appears while a request is in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe while idle");

    // The strobe lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // A miss reports a zero wall code, wall distance and texture step.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> wall_code == 4'd0 && wall_dist == 24'd0 && tex_step == 24'd0)
        else $error("miss with nonzero fields");

    // A hit always names a wall.
    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> wall_code != 4'd0)
        else $error("hit on empty cell");

    // A cast request keeps the block busy in the next cycle.
    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && kind |=> busy && !done)
        else $error("cast request not taken");

endmodule

bind grid_dda_wall_raycaster_top rdc_chk u_rdc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .done      (done),
    .hit       (hit),
    .wall_code (wall_code),
    .wall_dist (wall_dist),
    .tex_step  (tex_step)
);
`default_nettype wire

[dv/grid_dda_wall_raycaster_checker.sv]
// Checker for the grid DDA wall raycaster: watches the register port, the request and
// result channels, predicts each cast result and compares it. Depends on rdc_pkg.
`default_nettype none
module grid_dda_wall_raycaster_checker
    import rdc_pkg::*;
#(
    parameter logic KIND_CAST = 1'b1
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        kind,
    input  wire logic [4:0]  cell_x,
    input  wire logic [4:0]  cell_y,
    input  wire logic [3:0]  cell_code,
    input  wire logic [10:0] column,
    input  wire logic        done,
    input  wire logic [10:0] out_column,
    input  wire logic        hit,
    input  wire logic [3:0]  wall_code,
    input  wire logic        side,
    input  wire logic [23:0] wall_dist,
    input  wire logic [10:0] draw_start,
    input  wire logic [10:0] draw_end,
    input  wire logic [5:0]  tex_x,
    input  wire logic [23:0] tex_step,
    input  wire logic [27:0] tex_start,
    output int               errors,
    output int               pending
);

    localparam longint unsigned ONE      = 64'd1 << FRAC_BITS;
    localparam longint unsigned DIST_INF = 64'd1 << 60;
    localparam int              GRID     = 1 << MAP_BITS;
    localparam int              TEX_SIZE = 1 << TEX_BITS;

    typedef struct {
        logic [10:0] column;
        logic        hit;
        logic [3:0]  code;
        logic        side;
        logic [23:0] wdist;
        logic [10:0] dstart;
        logic [10:0] dend;
        logic [5:0]  tex_x;
        logic [23:0] tex_step;
        logic [27:0] tex_start;
    } stripe_t;

    logic        [20:0] cam_x, cam_y;
    logic signed [17:0] dir_x, dir_y, plane_x, plane_y;
    logic        [11:0] scr_w, scr_h;
    logic        [3:0]  cells [0:GRID*GRID-1];
    stripe_t            stripe_q [$];

    function automatic longint unsigned clip(longint unsigned v, longint unsigned max);
        return (v > max) ? max : v;
    endfunction

    // Per-axis DDA setup: delta distance, distance to the first boundary, step sign.
    function automatic void axis_init(input longint unsigned pos, input longint rd,
                                      output longint unsigned delta,
                                      output longint unsigned first,
                                      output int stp);
        longint unsigned fr;
        longint unsigned mag;
        longint unsigned f;
        fr  = pos & (ONE - 1);
        stp = (rd < 0) ? -1 : 1;
        if (rd == 0)
        begin
            delta = DIST_INF;
            first = DIST_INF;
        end
        else
        begin
            mag   = (rd < 0) ? longint'(-rd) : longint'(rd);
            f     = (rd < 0) ? fr : ONE - fr;
            delta = (64'd1 << (2 * FRAC_BITS)) / mag;
            first = (f << FRAC_BITS) / mag;
        end
    endfunction

    function automatic stripe_t trace_column(logic [10:0] col);
        stripe_t         r;
        longint unsigned w, h, dxd, dyd, sxd, syd, perp, lh, tstep, tstart, wall, tx, p, prod;
        longint          camx, rx, ry, mx, my, half_h, ds, de, rr;
        int              stx, sty, sd, s;
        bit              found;
        logic [3:0]      code;
        r        = '{default: '0};
        r.column = col;
        sd       = 0;
        found    = 0;
        code     = '0;
        w = (scr_w != 0) ? longint'(scr_w) : 1;
        h = (scr_h != 0) ? longint'(scr_h) : 1;
        camx = longint'(((2 * longint'(col)) << FRAC_BITS) / w) - longint'(ONE);
        rx = longint'(dir_x) + (longint'(plane_x) * camx) / longint'(ONE);
        ry = longint'(dir_y) + (longint'(plane_y) * camx) / longint'(ONE);
        if (rx == 0 && ry == 0)
            return r;
        axis_init(longint'(cam_x), rx, dxd, sxd, stx);
        axis_init(longint'(cam_y), ry, dyd, syd, sty);
        mx = longint'(cam_x >> FRAC_BITS);
        my = longint'(cam_y >> FRAC_BITS);
        // The starting cell is never tested; leaving the map ends the walk.
        for (s = 0; s < MAX_STEPS; s++)
        begin
            if (sxd < syd)
            begin
                sxd += dxd; mx += stx; sd = 0;
            end
            else
            begin
                syd += dyd; my += sty; sd = 1;
            end
            if (mx < 0 || my < 0 || mx >= GRID || my >= GRID)
                return r;
            code = cells[my * GRID + mx];
            if (code != 0)
            begin
                found = 1;
                break;
            end
        end
        if (!found)
            return r;
        perp = (sd == 0) ? sxd - dxd : syd - dyd;
        lh   = (perp == 0) ? longint'(LINE_MAX) : clip((h << FRAC_BITS) / perp, LINE_MAX);
        half_h = longint'(h / 2);
        ds = half_h - longint'(lh / 2);
        if (ds < 0) ds = 0;
        de = half_h + longint'(lh / 2);
        if (de >= longint'(h)) de = longint'(h) - 1;
        p    = (sd == 0) ? longint'(cam_y) : longint'(cam_x);
        rr   = (sd == 0) ? ry : rx;
        prod = perp * longint'(rr);
        wall = (p + (prod >> FRAC_BITS)) & (ONE - 1);
        tx   = (wall * TEX_SIZE) >> FRAC_BITS;
        if ((sd == 0 && rx > 0) || (sd == 1 && ry < 0))
            tx = TEX_SIZE - tx - 1;
        if (lh == 0)
        begin
            tstep  = 64'hFFFFFF;
            tstart = 0;
        end
        else
        begin
            tstep  = clip((longint'(TEX_SIZE) << FRAC_BITS) / lh, 64'hFFFFFF);
            tstart = clip(longint'(ds - half_h + longint'(lh / 2)) * tstep, START_MAX);
        end
        r.hit       = 1'b1;
        r.code      = code;
        r.side      = sd[0];
        r.wdist     = clip(perp, 64'hFFFFFF);
        r.dstart    = clip(ds, 64'h7FF);
        r.dend      = clip(de, 64'h7FF);
        r.tex_x     = tx[5:0];
        r.tex_step  = tstep[23:0];
        r.tex_start = tstart[27:0];
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    initial errors = 0;
    assign pending = stripe_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        stripe_t e;
        if (!rst_n)
        begin
            cam_x   <= 21'd65536;
            cam_y   <= 21'd65536;
            dir_x   <= -18'sd65536;
            dir_y   <= '0;
            plane_x <= '0;
            plane_y <= 18'sd43254;
            scr_w   <= 12'd640;
            scr_h   <= 12'd480;
            for (int i = 0; i < GRID * GRID; i++)
                cells[i] <= '0;
            stripe_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_reg_t'(paddr[4:2]))
                    REG_POS_X:   cam_x   <= pwdata[20:0];
                    REG_POS_Y:   cam_y   <= pwdata[20:0];
                    REG_DIR_X:   dir_x   <= pwdata[17:0];
                    REG_DIR_Y:   dir_y   <= pwdata[17:0];
                    REG_PLANE_X: plane_x <= pwdata[17:0];
                    REG_PLANE_Y: plane_y <= pwdata[17:0];
                    REG_SCR_W:   scr_w   <= pwdata[11:0];
                    REG_SCR_H:   scr_h   <= pwdata[11:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (kind == KIND_CAST)
                    stripe_q.push_back(trace_column(column));
                else
                    cells[{cell_y, cell_x}] <= cell_code;
            end
            if (done)
            begin
                if (stripe_q.size() == 0)
                begin
                    $error("result for column %0d with no request outstanding", out_column);
                    errors++;
                end
                else
                begin
                    e = stripe_q.pop_front();
                    check_field("out_column", e.column, out_column);
                    check_field("hit", e.hit, hit);
                    check_field("wall_code", e.code, wall_code);
                    check_field("side", e.side, side);
                    check_field("wall_dist", e.wdist, wall_dist);
                    check_field("draw_start", e.dstart, draw_start);
                    check_field("draw_end", e.dend, draw_end);
                    check_field("tex_x", e.tex_x, tex_x);
                    check_field("tex_step", e.tex_step, tex_step);
                    check_field("tex_start", e.tex_start, tex_start);
                end
            end
        end
    end

endmodule
`default_nettype wire

[dv/grid_dda_wall_raycaster_top_tb.sv]
// Testbench top for the grid DDA wall raycaster: clock, reset, register and request
// stimulus, and the verdict. Depends on rdc_pkg, grid_dda_wall_raycaster_top and grid_dda_wall_raycaster_checker.
`default_nettype none
module grid_dda_wall_raycaster_top_tb;
    import rdc_pkg::*;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;
    localparam int   CYCLE_LIMIT = 3000000;
    localparam int   DRAIN_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic        kind = 1'b0;
    logic [4:0]  cell_x = '0, cell_y = '0;
    logic [3:0]  cell_code = '0;
    logic [10:0] column = '0;
    logic        done, hit, side;
    logic [10:0] out_column, draw_start, draw_end;
    logic [3:0]  wall_code;
    logic [23:0] wall_dist, tex_step;
    logic [5:0]  tex_x;
    logic [27:0] tex_start;
    int          errors, pending;
    int          cycles = 0;
    int          cur_width = 640;

    always #4 clk = ~clk;

    grid_dda_wall_raycaster_top dut (.*);

    grid_dda_wall_raycaster_checker #(.KIND_CAST(KIND_CAST)) chk (.*);

    // Watchdog: the run must finish well within the cycle budget.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // One APB write: setup cycle then access cycle. The select is left high so that
    // back-to-back writes never assign it twice in one step; the caller drops it.
    task automatic reg_write(cfg_reg_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic load_view(logic [20:0] px, logic [20:0] py, logic [17:0] dx,
                             logic [17:0] dy, logic [17:0] plx, logic [17:0] ply,
                             logic [11:0] w, logic [11:0] h);
        reg_write(REG_POS_X, px);
        reg_write(REG_POS_Y, py);
        reg_write(REG_DIR_X, dx);
        reg_write(REG_DIR_Y, dy);
        reg_write(REG_PLANE_X, plx);
        reg_write(REG_PLANE_Y, ply);
        reg_write(REG_SCR_W, w);
        reg_write(REG_SCR_H, h);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_width = (w == 0) ? 1 : w;
    endtask

    // Registers may only change while the block is idle: the request line is dropped,
    // every result has come back and busy is low; a cell write is already stored at the
    // edge that takes it. Both are sampled at the falling edge, after the block has updated.
    task automatic wait_quiet();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Present one request and hold it until it is taken. Busy is sampled at the
    // falling edge, so the decision does not race the block's own update.
    task automatic send(logic k, logic [4:0] x, logic [4:0] y, logic [3:0] c,
                        logic [10:0] col);
        start     <= 1'b1;
        kind      <= k;
        cell_x    <= x;
        cell_y    <= y;
        cell_code <= c;
        column    <= col;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
    endtask

    // Gap after a request: mostly none or short, now and then long.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) < 5) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 120);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic cast(logic [10:0] col);
        send(KIND_CAST, 5'($urandom), 5'($urandom), 4'($urandom), col);
        idle_gap();
    endtask

    task automatic put_cell(logic [4:0] x, logic [4:0] y, logic [3:0] c);
        send(KIND_WRITE, x, y, c, 11'($urandom));
        idle_gap();
    endtask

    function automatic logic [20:0] rand_pos();
        logic [4:0]  ip;
        logic [15:0] fp;
        ip = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 30));
        fp = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        return {ip, fp};
    endfunction

    function automatic logic [17:0] rand_vec();
        int mag;
        mag = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 80000);
        return ($urandom_range(0, 1) != 0) ? 18'(-mag) : 18'(mag);
    endfunction

    function automatic logic [11:0] rand_size();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 12'd0;
        if (sel == 1)
            return 12'd1;
        if (sel == 2)
            return 12'd2048;
        return 12'($urandom_range(1, 2048));
    endfunction

    initial
    begin
        int sent;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty map: every ray leaves the grid without a hit.
        cast(11'd0);
        cast(11'd320);
        cast(11'd2047);
        // Extreme cells and codes, including clearing a cell again.
        put_cell(5'd0, 5'd0, 4'd15);
        put_cell(5'd31, 5'd31, 4'd15);
        put_cell(5'd31, 5'd31, 4'd0);
        put_cell(5'd0, 5'd1, 4'd9);
        put_cell(5'd0, 5'd2, 4'd1);
        // Reset view looks toward -x from (1,1): wall at (0,1), one cell away.
        cast(11'd320);
        cast(11'd0);
        cast(11'd639);
        wait_quiet();
        // Camera on a cell boundary facing the wall next to it: zero distance.
        load_view(21'd65536, 21'd98304, -18'sd65536, 18'd0, 18'd0, 18'd0,
                  12'd480, 12'd480);
        cast(11'd240);
        wait_quiet();
        // Zero ray, extreme positions and vectors, zero screen registers.
        load_view(21'd0, 21'd0, 18'd0, 18'd0, 18'd0, 18'd0, 12'd0, 12'd0);
        cast(11'd0);
        cast(11'd2047);
        wait_quiet();
        load_view(21'd2097151, 21'd2097151, 18'sd131071, 18'sd131071,
                  -18'sd131072, -18'sd131072, 12'd2048, 12'd2048);
        cast(11'd1024);
        cast(11'd2047);
        wait_quiet();
        load_view(21'd983040, 21'd983040, -18'sd131072, 18'sd131071,
                  18'sd131071, -18'sd131072, 12'd1, 12'd2048);
        cast(11'd0);
        cast(11'd1);
        wait_quiet();

        // Surround the map with walls so that most rays stop on something.
        for (int i = 0; i < 32; i++)
        begin
            put_cell(5'(i), 5'd0, 4'($urandom_range(1, 15)));
            put_cell(5'(i), 5'd31, 4'($urandom_range(1, 15)));
            put_cell(5'd0, 5'(i), 4'($urandom_range(1, 15)));
            put_cell(5'd31, 5'(i), 4'($urandom_range(1, 15)));
        end

        // Random part: phases of a fresh view, each followed by casts and map edits.
        sent = 0;
        while (sent < 1100)
        begin
            wait_quiet();
            load_view(rand_pos(), rand_pos(), rand_vec(), rand_vec(), rand_vec(),
                      rand_vec(), rand_size(), rand_size());
            repeat ($urandom_range(60, 140))
            begin
                if ($urandom_range(0, 99) < 65)
                    cast(($urandom_range(0, 9) == 0) ? 11'($urandom)
                                                     : 11'($urandom_range(0, cur_width - 1)));
                else
                    put_cell(5'($urandom), 5'($urandom),
                             ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom));
                sent++;
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_div.sv
hw/rtl/rdc_map.sv
hw/rtl/grid_dda_wall_raycaster_top.sv
hw/rtl/rdc_chk.sv
dv/grid_dda_wall_raycaster_checker.sv
dv/grid_dda_wall_raycaster_top_tb.sv
